/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of the parity encoder.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define GFPE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gfpe: check failed");

// Clocked check that also runs during reset.
`define GFPE_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gfpe: reset check failed");

`endif

/* rtl/core/gfpe_pkg.sv */
// Shared widths, register codes, GF(2^8) log/exp tables and stage types
// for the erasure parity encoder. No dependencies.
`timescale 1ns / 1ps

package gfpe_pkg;

   localparam int DATA_W    = 8;
   localparam int SHARD_W   = 5;
   localparam int POS_W     = 11;
   localparam int PAR_W     = 4;
   localparam int DS_W      = 8;
   localparam int PROD_W    = DATA_W + SHARD_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int DEF_MAX_DATA    = 20;
   localparam int DEF_MAX_PARITY  = 10;
   localparam int DEF_SHARD_BYTES = 2048;

   localparam int DS_RESET = 5;
   localparam int PS_RESET = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DATA_SHARDS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PARITY_SHARDS = 2'd1;

   localparam logic [8:0] GF_POLY  = 9'h11d;
   localparam logic [8:0] GF_ORDER = 9'd255;

   typedef logic [DATA_W-1:0] gf_table_type [256];

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             emit;
      logic             dnz;
      logic [POS_W-1:0] pos;
   } stage_ctl_type;

   function automatic gf_table_type gen_exp_table();
      gf_table_type t;
      logic [8:0]   v;
      v = 9'd1;
      for (int i = 0; i < 256; i++) begin
         t[i] = v[7:0];
         v = {v[7:0], 1'b0};
         if (v[8]) begin
            v = v ^ GF_POLY;
         end
      end
      return t;
   endfunction

   function automatic gf_table_type gen_log_table();
      gf_table_type t;
      gf_table_type e;
      e = gen_exp_table();
      for (int i = 0; i < 256; i++) begin
         t[i] = '0;
      end
      for (int i = 0; i < 255; i++) begin
         t[e[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam gf_table_type GF_EXP = gen_exp_table();
   localparam gf_table_type GF_LOG = gen_log_table();

endpackage

/* rtl/core/gfpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds one parity lane's accumulators.
`timescale 1ns / 1ps

module gfpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/gf256_erasure_parity_encoder_unit.sv */
// Erasure parity encoder over GF(2^8), poly 0x11d, Vandermonde rows.
// Input transfer (req_*): one data byte with its shard index and byte
// position; shards must arrive shard 0 first. Bytes with a shard index at
// or above the data shard count, or a position beyond the shard size, are
// dropped.
// Result transfer (rsp_*): when the last data shard's byte for a position
// has been folded in, one result per parity shard follows, parity_index 0
// first, rsp_last on the final one.
// Throughput: one byte per cycle unless stalled, through a five stage pipeline
// (capture, log lookup and multiply, mod-255 fold, exp lookup, read-modify-write
// of one RAM per parity lane). A last-shard byte holds the output buffer until
// its results, one per parity shard, have left; the next one stalls in the last
// stage until then.
// rsp_stall freezes the whole pipeline only when a second result group is
// ready to leave while the buffer still drains; nothing is lost or redone.
// csr_*: data shard count (index 0) and parity shard count (index 1), written
// while idle, always ready. Reset restores 5 and 2 and empties the pipeline;
// the accumulator RAMs are not cleared, shard 0 overwrites them.
`timescale 1ns / 1ps

module gf256_erasure_parity_encoder_unit #(
   parameter int MAX_DATA    = gfpe_pkg::DEF_MAX_DATA,
   parameter int MAX_PARITY  = gfpe_pkg::DEF_MAX_PARITY,
   parameter int SHARD_BYTES = gfpe_pkg::DEF_SHARD_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gfpe_pkg::DATA_W-1:0]       req_data_byte,
   input  logic [gfpe_pkg::SHARD_W-1:0]      req_shard_index,
   input  logic [gfpe_pkg::POS_W-1:0]        req_byte_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gfpe_pkg::DATA_W-1:0]       rsp_parity_byte,
   output logic [gfpe_pkg::PAR_W-1:0]        rsp_parity_index,
   output logic [gfpe_pkg::POS_W-1:0]        rsp_out_position,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gfpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gfpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gfpe_pkg::*;

   localparam int LANES  = MAX_PARITY;
   localparam int ADDR_W = $clog2(SHARD_BYTES);

   // configuration
   logic [SHARD_W-1:0] cfg_ds_ff, cfg_ds_in;
   logic [PAR_W-1:0]   cfg_ps_ff, cfg_ps_in;
   logic [DS_W-1:0]    ds_eff;
   logic [PAR_W-1:0]   ps_eff;

   // per-lane values derived from configuration
   logic [DATA_W-1:0] logx_ff [LANES];
   logic [LANES-1:0]  xz_ff;
   logic [LANES-1:0]  lane_en_ff;
   logic [PAR_W-1:0]  last_idx_ff;

   // pipeline
   stage_ctl_type s1_ctl_ff, s1_ctl_in;
   stage_ctl_type s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff;
   logic [DATA_W-1:0]  s1_byte_ff;
   logic [SHARD_W-1:0] s1_d_ff;
   logic [DATA_W-1:0]  s2_lb_ff, s3_lb_ff;
   logic               s2_bz_ff, s3_bz_ff;
   logic [PROD_W-1:0]  prod_ff  [LANES];
   logic [DATA_W-1:0]  lc_ff    [LANES];
   logic [LANES-1:0]   cz_ff;
   logic [DATA_W-1:0]  term4_ff [LANES];
   logic [DATA_W-1:0]  term5_ff [LANES];
   logic [DATA_W-1:0]  rdata    [LANES];
   logic [DATA_W-1:0]  newv     [LANES];

   // write forwarding of the last committed accumulator values
   logic              fwd_v_ff;
   logic [POS_W-1:0]  fwd_pos_ff;
   logic [DATA_W-1:0] fwd_data_ff [LANES];
   logic              fwd_hit;

   // output buffer
   logic              ob_busy_ff, ob_busy_in;
   logic [PAR_W-1:0]  ob_idx_ff, ob_idx_in;
   logic [PAR_W-1:0]  ob_last_ff, ob_last_in;
   logic [POS_W-1:0]  ob_pos_ff, ob_pos_in;
   logic [DATA_W-1:0] ob_data_ff [LANES];
   logic [DATA_W-1:0] ob_data_in [LANES];

   logic adv, commit, load, xfer, ob_fin;
   logic [ADDR_W-1:0] raddr;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_ds_in = cfg_ds_ff;
      cfg_ps_in = cfg_ps_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DATA_SHARDS:   cfg_ds_in = csr_wdata[SHARD_W-1:0];
            REG_PARITY_SHARDS: cfg_ps_in = csr_wdata[PAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ds_ff <= SHARD_W'(DS_RESET);
         cfg_ps_ff <= PAR_W'(PS_RESET);
      end else begin
         cfg_ds_ff <= cfg_ds_in;
         cfg_ps_ff <= cfg_ps_in;
      end
   end

   assign ds_eff = (int'(cfg_ds_ff) > MAX_DATA) ? DS_W'(MAX_DATA) : DS_W'(cfg_ds_ff);
   assign ps_eff = (int'(cfg_ps_ff) > MAX_PARITY) ? PAR_W'(MAX_PARITY) : cfg_ps_ff;

   always_ff @(posedge clock) begin
      last_idx_ff <= ps_eff - PAR_W'(1);
   end

   // ---------------- handshake ----------------
   assign xfer      = ob_busy_ff && !rsp_stall;
   assign ob_fin    = xfer && rsp_last;
   assign adv       = !(s5_ctl_ff.valid && s5_ctl_ff.emit && ob_busy_ff && !ob_fin);
   assign req_stall = !adv;
   assign commit    = s5_ctl_ff.valid && adv;
   assign load      = commit && s5_ctl_ff.emit;

   // ---------------- stage 1: capture and filter ----------------
   always_comb begin
      s1_ctl_in.valid = req_valid && (ds_eff != '0)
                        && (DS_W'(req_shard_index) < ds_eff)
                        && (13'(req_byte_position) < 13'(SHARD_BYTES));
      s1_ctl_in.first = (req_shard_index == '0);
      s1_ctl_in.emit  = (DS_W'(req_shard_index) == ds_eff - DS_W'(1)) && (ps_eff != '0);
      s1_ctl_in.dnz   = (req_shard_index != '0);
      s1_ctl_in.pos   = req_byte_position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   // stage 2 log of the byte, stage 3 pass-through
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_byte_ff <= req_data_byte;
         s1_d_ff    <= req_shard_index;
         s2_lb_ff   <= GF_LOG[s1_byte_ff];
         s2_bz_ff   <= (s1_byte_ff == '0);
         s3_lb_ff   <= s2_lb_ff;
         s3_bz_ff   <= s2_bz_ff;
      end
   end

   assign raddr   = adv ? ADDR_W'(s4_ctl_ff.pos) : ADDR_W'(s5_ctl_ff.pos);
   assign fwd_hit = fwd_v_ff && (fwd_pos_ff == s5_ctl_ff.pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= 1'b0;
      end else begin
         fwd_v_ff <= commit;
      end
   end

   always_ff @(posedge clock) begin
      fwd_pos_ff <= s5_ctl_ff.pos;
   end

   // ---------------- parity lanes ----------------
   for (genvar p = 0; p < LANES; p++) begin : g_lane
      logic [DATA_W-1:0] xv;
      logic [8:0]        fold;
      logic [8:0]        esum;
      logic [DATA_W-1:0] lc_in;
      logic [DATA_W-1:0] e_idx;
      logic [DATA_W-1:0] term_in;
      logic [DATA_W-1:0] prev;

      assign xv = DATA_W'(int'(ds_eff) + p + 1);

      always_ff @(posedge clock) begin
         logx_ff[p]    <= GF_LOG[xv];
         xz_ff[p]      <= (xv == '0);
         lane_en_ff[p] <= (int'(ps_eff) > p);
      end

      // log(x^d) = d * log(x) mod 255; 256 == 1 so fold the high bits in
      assign fold  = 9'(prod_ff[p][PROD_W-1:DATA_W]) + 9'(prod_ff[p][DATA_W-1:0]);
      assign lc_in = (fold >= GF_ORDER) ? DATA_W'(fold - GF_ORDER) : fold[DATA_W-1:0];

      assign esum    = 9'(s3_lb_ff) + 9'(lc_ff[p]);
      assign e_idx   = (esum >= GF_ORDER) ? DATA_W'(esum - GF_ORDER) : esum[DATA_W-1:0];
      assign term_in = (s3_bz_ff || cz_ff[p]) ? '0 : GF_EXP[e_idx];

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff[p]  <= PROD_W'(logx_ff[p]) * PROD_W'(s1_d_ff);
            lc_ff[p]    <= xz_ff[p] ? '0 : lc_in;
            // x wrapped to zero: x^d is zero for any d but 0
            cz_ff[p]    <= xz_ff[p] && s2_ctl_ff.dnz;
            term4_ff[p] <= term_in;
            term5_ff[p] <= term4_ff[p];
         end
      end

      assign prev    = fwd_hit ? fwd_data_ff[p] : rdata[p];
      assign newv[p] = s5_ctl_ff.first ? term5_ff[p] : (prev ^ term5_ff[p]);

      always_ff @(posedge clock) begin
         fwd_data_ff[p] <= newv[p];
      end

      gfpe_ram #(
         .WIDTH (DATA_W),
         .DEPTH (SHARD_BYTES)
      ) u_acc (
         .clock (clock),
         .we    (commit && lane_en_ff[p]),
         .waddr (ADDR_W'(s5_ctl_ff.pos)),
         .wdata (newv[p]),
         .raddr (raddr),
         .rdata (rdata[p])
      );

      if (p == LANES - 1) begin : g_tail
         assign ob_data_in[p] = load ? newv[p] : (xfer ? '0 : ob_data_ff[p]);
      end else begin : g_body
         assign ob_data_in[p] = load ? newv[p] : (xfer ? ob_data_ff[p+1] : ob_data_ff[p]);
      end

      always_ff @(posedge clock) begin
         ob_data_ff[p] <= ob_data_in[p];
      end
   end

   // ---------------- output buffer ----------------
   always_comb begin
      ob_busy_in = ob_busy_ff;
      ob_idx_in  = ob_idx_ff;
      ob_last_in = ob_last_ff;
      ob_pos_in  = ob_pos_ff;
      if (load) begin
         ob_busy_in = 1'b1;
         ob_idx_in  = '0;
         ob_last_in = last_idx_ff;
         ob_pos_in  = s5_ctl_ff.pos;
      end else if (xfer) begin
         if (rsp_last) begin
            ob_busy_in = 1'b0;
         end else begin
            ob_idx_in = ob_idx_ff + PAR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_busy_ff <= 1'b0;
      end else begin
         ob_busy_ff <= ob_busy_in;
      end
      ob_idx_ff  <= ob_idx_in;
      ob_last_ff <= ob_last_in;
      ob_pos_ff  <= ob_pos_in;
   end

   assign rsp_valid        = ob_busy_ff;
   assign rsp_parity_byte  = ob_data_ff[0];
   assign rsp_parity_index = ob_idx_ff;
   assign rsp_out_position = ob_pos_ff;
   assign rsp_last         = (ob_idx_ff == ob_last_ff);

endmodule

/* rtl/core/gfpe_checker.sv */
// Port-level checks for the parity encoder and the bind that attaches them.
// Depends on gfpe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfpe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [gfpe_pkg::DATA_W-1:0]  rsp_parity_byte,
   input logic [gfpe_pkg::PAR_W-1:0]   rsp_parity_index,
   input logic [gfpe_pkg::POS_W-1:0]   rsp_out_position,
   input logic                         rsp_last
);

   // stalled result holds
   `GFPE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parity_byte) && $stable(rsp_parity_index) && $stable(rsp_out_position) && $stable(rsp_last))

   // a group runs out without gaps, index counting up at one position
   `GFPE_ASSERT(a_group_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && (rsp_parity_index == $past(rsp_parity_index) + 1'b1) && $stable(rsp_out_position))

   // a group that follows right after another starts at parity 0
   `GFPE_ASSERT(a_group_start, clock, reset, rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid || (rsp_parity_index == '0))

   // the input only backs up behind pending results
   `GFPE_ASSERT(a_idle_ready, clock, reset, req_valid && !rsp_valid |-> !req_stall)

   // reset empties the output
   `GFPE_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind gf256_erasure_parity_encoder_unit gfpe_checker u_gfpe_checker (.*);
